// File: hdl/b64e_pkg.sv
// Shared types, constants and the character mapping of the Base64 stream encoder.
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [6:0] CharPad       = 7'h3D; // '='
  localparam logic [6:0] CharPlus      = 7'h2B; // '+'
  localparam logic [6:0] CharSlash     = 7'h2F; // '/'
  localparam logic [6:0] CharDash      = 7'h2D; // '-'
  localparam logic [6:0] CharUnderline = 7'h5F; // '_'
  localparam logic [6:0] CharUpperA    = 7'h41; // 'A'
  localparam logic [6:0] CharLowerA    = 7'h61; // 'a'
  localparam logic [6:0] CharDigit0    = 7'h30; // '0'

  // One source group: up to three bytes, missing bytes are zero
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  nbytes;
    logic        last;
  } b64e_group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  function automatic logic [6:0] code_char(input logic [5:0] code, input logic url);
    logic [6:0] c;
    begin
      c = {1'b0, code};
      if (code < 6'd26) begin
        code_char = CharUpperA + c;
      end else if (code < 6'd52) begin
        code_char = CharLowerA + (c - 7'd26);
      end else if (code < 6'd62) begin
        code_char = CharDigit0 + (c - 7'd52);
      end else if (code == 6'd62) begin
        code_char = url ? CharDash : CharPlus;
      end else begin
        code_char = url ? CharUnderline : CharSlash;
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64e_front.sv
// Front end: collects raw bytes into groups of up to three and queues each group.
`default_nettype none

module b64e_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire b64e_pkg::b64e_qstat_t qstat,
  output logic                      full,
  output logic                      q_push,
  output b64e_pkg::b64e_group_t     q_data
);
  import b64e_pkg::*;

  localparam logic [1:0] PosNone = 2'd0;
  localparam logic [1:0] PosOne  = 2'd1;
  localparam logic [1:0] PosTwo  = 2'd2;

  logic [1:0]  pos, pos_next;
  logic [15:0] held, held_next;
  logic        accept;

  assign full   = qstat.full;
  assign accept = push && !full;

  always_comb begin
    pos_next      = pos;
    held_next     = held;
    q_push        = 1'b0;
    q_data.bytes  = 24'd0;
    q_data.nbytes = 2'd1;
    q_data.last   = last_byte;
    if (accept) begin
      unique case (pos)
        PosOne: begin
          if (last_byte) begin
            q_push        = 1'b1;
            q_data.bytes  = {held[15:8], data_byte, 8'd0};
            q_data.nbytes = 2'd2;
            pos_next      = PosNone;
          end else begin
            held_next = {held[15:8], data_byte};
            pos_next  = PosTwo;
          end
        end
        PosTwo: begin
          q_push        = 1'b1;
          q_data.bytes  = {held, data_byte};
          q_data.nbytes = 2'd3;
          pos_next      = PosNone;
        end
        default: begin
          // empty group; the unused code 3 behaves the same
          if (last_byte) begin
            q_push        = 1'b1;
            q_data.bytes  = {data_byte, 16'd0};
            q_data.nbytes = 2'd1;
            pos_next      = PosNone;
          end else begin
            held_next = {data_byte, 8'd0};
            pos_next  = PosOne;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    if (rst) begin
      pos <= PosNone;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64e_queue.sv
// Short register queue of byte groups between the front and back ends.
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr,
  input  wire b64e_pkg::b64e_group_t wr_data,
  input  wire logic                  rd,
  output b64e_pkg::b64e_group_t      rd_data,
  output b64e_pkg::b64e_qstat_t      qstat
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64e_group_t     slots [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign qstat.full  = (count == CntFull);
  assign qstat.empty = (count == '0);
  assign do_wr       = wr && !qstat.full;
  assign do_rd       = rd && !qstat.empty;
  assign rd_data     = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64e_back.sv
// Back end: turns each queued group into four registered characters, one per cycle when not held.
`default_nettype none

module b64e_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  url_alphabet,
  input  wire b64e_pkg::b64e_group_t q_data,
  input  wire b64e_pkg::b64e_qstat_t qstat,
  output logic                       q_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [6:0]                 out_char,
  output logic                       end_of_text
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic [5:0] code;
  logic [6:0] ch;

  assign empty = !out_valid;
  assign load  = !qstat.empty && (!out_valid || pop);
  assign q_pop = load && (idx == 2'd3);

  always_comb begin
    unique case (idx)
      2'd0:    code = q_data.bytes[23:18];
      2'd1:    code = q_data.bytes[17:12];
      2'd2:    code = q_data.bytes[11:6];
      default: code = q_data.bytes[5:0];
    endcase
    // positions past the real bytes become padding
    ch = (idx > q_data.nbytes) ? CharPad : code_char(code, url_alphabet);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= ch;
      end_of_text <= q_data.last && (idx == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: front end, group queue, back end, config register.
// A byte that closes a group is written into the queue, then its first character is loaded into the output
// register; the rest follow one per cycle while the receiver pops.
// The back end emits four characters per group of three bytes; the front takes a byte per
// cycle unless the queue is full.
// Reset (rst, synchronous): queue and output empty, group cleared, standard alphabet.
`default_nettype none

module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char,
  output logic            end_of_text,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);
  import b64e_pkg::*;

  b64e_group_t front_group, head_group;
  b64e_qstat_t qstat;
  logic        q_push, q_pop;
  logic        url_alphabet;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      url_alphabet <= cfg_data;
    end
  end

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .qstat     (qstat),
    .full      (full),
    .q_push    (q_push),
    .q_data    (front_group)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (front_group),
    .rd      (q_pop),
    .rd_data (head_group),
    .qstat   (qstat)
  );

  b64e_back u_back (
    .clk          (clk),
    .rst          (rst),
    .url_alphabet (url_alphabet),
    .q_data       (head_group),
    .qstat        (qstat),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_char     (out_char),
    .end_of_text  (end_of_text)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("group written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("group dropped from an empty queue");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && qstat.empty))
    else $error("output or queue not empty after reset");

endmodule

`default_nettype wire

// File: bench/tb_base64_stream_encoder.sv
// Self-checking testbench for the Base64 stream encoder: directed, random and backpressure tests.
module tb_base64_stream_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomBytes  = 180;

  typedef struct {
    logic [6:0] ch;
    logic       eot;
  } enc_char_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty;
  logic       pop;
  logic [6:0] out_char;
  logic       end_of_text;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  // Encoder state mirrored on the bench side
  logic        url_sel;
  logic [1:0]  group_pos;
  logic [15:0] held_pair;
  enc_char_t   pending_chars[$];

  int unsigned err_count;
  int unsigned idle_cycles;
  int unsigned rx_wait;
  int unsigned hold_left;
  bit          hold_req;
  bit          tx_no_gap;
  int unsigned bytes_sent;

  string std_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .empty      (empty),
    .pop        (pop),
    .out_char   (out_char),
    .end_of_text(end_of_text),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [6:0] sextet_char(logic [5:0] v);
    byte c;
    if (url_sel && v == 6'd62) return CharDash;
    if (url_sel && v == 6'd63) return CharUnderline;
    c = std_alphabet[v];
    return c[6:0];
  endfunction

  function automatic void add_char(logic [6:0] ch, logic eot);
    enc_char_t e;
    e.ch  = ch;
    e.eot = eot;
    pending_chars.push_back(e);
  endfunction

  // Advance the mirrored encoder by one accepted byte and queue its characters
  function automatic void encode_byte(logic [7:0] b, logic is_last);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] pos;
    pos = (group_pos == 2'd3) ? 2'd0 : group_pos;
    b0  = held_pair[15:8];
    b1  = held_pair[7:0];
    if (!is_last && pos != 2'd2) begin
      if (pos == 2'd0) held_pair = {b, 8'h00};
      else held_pair = {b0, b};
      group_pos = pos + 2'd1;
      return;
    end
    case (pos)
      2'd0: begin
        add_char(sextet_char(b[7:2]), 1'b0);
        add_char(sextet_char({b[1:0], 4'h0}), 1'b0);
        add_char(CharPad, 1'b0);
        add_char(CharPad, 1'b1);
      end
      2'd1: begin
        add_char(sextet_char(b0[7:2]), 1'b0);
        add_char(sextet_char({b0[1:0], b[7:4]}), 1'b0);
        add_char(sextet_char({b[3:0], 2'b00}), 1'b0);
        add_char(CharPad, 1'b1);
      end
      default: begin
        add_char(sextet_char(b0[7:2]), 1'b0);
        add_char(sextet_char({b0[1:0], b1[7:4]}), 1'b0);
        add_char(sextet_char({b1[3:0], b[7:6]}), 1'b0);
        add_char(sextet_char(b[5:0]), is_last);
      end
    endcase
    group_pos = 2'd0;
    held_pair = 16'h0000;
  endfunction

  // Receiver: random pop gaps, plus one long hold-off on request
  initial begin
    pop       = 1'b0;
    rx_wait   = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    enc_char_t e;
    if (!rst && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h eot %b",
                 $time, out_char, end_of_text);
        err_count++;
      end else begin
        e = pending_chars.pop_front();
        if (out_char !== e.ch) begin
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, e.ch, out_char);
          err_count++;
        end
        if (end_of_text !== e.eot) begin
          $display("%0t: end_of_text mismatch: expected %b, actual %b",
                   $time, e.eot, end_of_text);
          err_count++;
        end
      end
      rx_wait = tx_no_gap ? 0 : pick_gap();
    end
  end

  // Watchdog: end the run if no transaction happens for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic is_last);
    int unsigned gap;
    gap = tx_no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // Stop offering, wait for every queued character, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_alphabet(logic url);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= url;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    url_sel = url;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_standard_directed();
    write_alphabet(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    // full group not last, then a full group, then a lone closing byte
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();
  endtask

  task automatic test_url_directed();
    write_alphabet(1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEF, 1'b1);
    drain();
  endtask

  task automatic test_random_messages();
    int unsigned phase;
    int unsigned target;
    phase = 0;
    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      case (phase)
        0: write_alphabet(1'b0);
        1: write_alphabet(1'b1);
        default: write_alphabet(1'($urandom));
      endcase
      // a stretch with no idling on either side now and then
      tx_no_gap = (phase % 3 == 2);
      for (int unsigned m = 0; m < 8; m++) begin
        if ($urandom_range(0, 9) == 0) send_message($urandom_range(10, 30));
        else send_message($urandom_range(1, 9));
      end
      tx_no_gap = 1'b0;
      phase++;
    end
    drain();
  endtask

  task automatic test_backpressure();
    write_alphabet(1'($urandom));
    tx_no_gap = 1'b1;
    hold_req  = 1'b1;
    send_message(40);
    tx_no_gap = 1'b0;
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    data_byte  = 8'h00;
    last_byte  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    url_sel    = 1'b0;
    group_pos  = 2'd0;
    held_pair  = 16'h0000;
    err_count  = 0;
    idle_cycles = 0;
    hold_req   = 1'b0;
    tx_no_gap  = 1'b0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_standard_directed();
    test_url_directed();
    test_backpressure();
    test_random_messages();
    drain();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
bench/tb_base64_stream_encoder.sv
